// ----- design/circular_doubly_linked_list_engine_defines.svh -----
// Assertion macros used by the list engine RTL.
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define CDLL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define CDLL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define CDLL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CDLL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/cdll_pkg.sv -----
package cdll_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 3;
    localparam int CNT_O_W  = 9;

    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OOB      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_GETN,
        S_WISSUE,
        S_WALK,
        S_SRCH,
        S_LINK1,
        S_LINK2,
        S_DTAIL,
        S_DTAILC,
        S_DISSUE,
        S_DUNLINK,
        S_DONE
    } t_state;

    // free-node allocator controls
    typedef struct packed {
        logic rd_req;   // start a pop: read top of stack
        logic pop;      // take the node, cycle after rd_req
        logic push;     // return a node
    } t_free_ctl;

endpackage

// ----- design/cdll_ram.sv -----
module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cdll_free.sv -----
module cdll_free import cdll_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_free_ctl                   i_ctl,
    input  logic [$clog2(CAPACITY)-1:0] i_push_idx,
    output logic [$clog2(CAPACITY)-1:0] o_node
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // r_used: nodes never handed out sit above this mark; stack holds returned ones
    logic [CW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_used, n_used;
    logic          r_from_stk;
    logic [IW-1:0] stk_rdata;
    logic [CW-1:0] sp_dec;

    assign sp_dec = r_sp - 1'b1;

    cdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_sp[IW-1:0]),
        .i_wdata (i_push_idx),
        .i_raddr (sp_dec[IW-1:0]),
        .o_rdata (stk_rdata)
    );

    assign o_node = r_from_stk ? stk_rdata : r_used[IW-1:0];

    always_comb begin
        n_sp   = r_sp;
        n_used = r_used;
        if (i_ctl.push) begin
            n_sp = r_sp + 1'b1;
        end else if (i_ctl.pop) begin
            if (r_from_stk) begin
                n_sp = sp_dec;
            end else begin
                n_used = r_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_used     <= '0;
            r_from_stk <= 1'b0;
        end else begin
            r_sp   <= n_sp;
            r_used <= n_used;
            if (i_ctl.rd_req) begin
                r_from_stk <= (r_sp != '0);
            end
        end
    end

endmodule

// ----- design/circular_doubly_linked_list_engine.sv -----
// Channel   Handshake              Payload
// request   i_valid / o_ready      i_mode, i_value, i_position
// result    o_valid / i_ready      o_status, o_removed_value, o_found_position, o_node_count
//
// One request at a time; the result register holds until taken.
// Front/back ops and rejects do not walk the list. Positional ops walk the next-link memory one
// node per cycle, as does a search, which stops at a match or after count nodes.
// The walk rate is set by the single read port of the link memory.
// Reset (i_rst_n low, synchronous) empties the list at once; node memories need no clearing.
`include "circular_doubly_linked_list_engine_defines.svh"
module circular_doubly_linked_list_engine import cdll_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]           i_position,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VALUE_W-1:0]  o_removed_value,
    output logic [CNT_O_W-1:0]         o_found_position,
    output logic [CNT_O_W-1:0]         o_node_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;

    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic                r_front, n_front;
    logic [IW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_cur, n_cur;
    logic [IW-1:0]       r_at, n_at;
    logic [IW-1:0]       r_nx, n_nx;
    logic [IW-1:0]       r_node, n_node;
    logic [CW-1:0]       r_steps, n_steps;
    logic [CW-1:0]       r_idx, n_idx;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VALUE_W-1:0]  r_removed, n_removed;
    logic [CW-1:0]       r_found, n_found;

    logic          in_fire;
    logic [31:0]   pos_ext;
    logic [31:0]   cnt_ext;
    logic          full;

    logic [IW-1:0]      node_raddr;
    logic [VALUE_W-1:0] val_rdata;
    logic [IW-1:0]      nxt_rdata;
    logic [IW-1:0]      prv_rdata;
    logic               val_we, nxt_we, prv_we;
    logic [IW-1:0]      nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
    t_free_ctl          free_ctl;
    logic [IW-1:0]      free_node;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign in_fire = i_valid && o_ready;
    assign pos_ext = 32'(i_position);
    assign cnt_ext = 32'(r_count);
    assign full    = (r_count == CW'(CAPACITY));

    cdll_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_node),
        .i_wdata (r_value),
        .i_raddr (node_raddr),
        .o_rdata (val_rdata)
    );

    cdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (node_raddr),
        .o_rdata (nxt_rdata)
    );

    cdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_waddr),
        .i_wdata (prv_wdata),
        .i_raddr (node_raddr),
        .o_rdata (prv_rdata)
    );

    cdll_free #(.CAPACITY(CAPACITY)) u_free (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (free_ctl),
        .i_push_idx (r_cur),
        .o_node     (free_node)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_mode)
                        MODE_INS_FRONT, MODE_INS_BACK: begin
                            n_state = full ? S_DONE : S_ALLOC;
                        end
                        MODE_INS_POS: begin
                            if (pos_ext == 32'd0 || pos_ext > cnt_ext + 32'd1 || full) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        MODE_SEARCH: n_state = (r_count == '0) ? S_DONE : S_WISSUE;
                        MODE_DEL_FRONT: n_state = (r_count == '0) ? S_DONE : S_DISSUE;
                        MODE_DEL_BACK: n_state = (r_count == '0) ? S_DONE : S_DTAIL;
                        MODE_DEL_POS: begin
                            if (r_count == '0 || pos_ext == 32'd0 || pos_ext > cnt_ext) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_WISSUE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ALLOC: n_state = S_GETN;
            S_GETN: begin
                if (r_mode == MODE_INS_POS && !r_front) begin
                    n_state = S_WISSUE;
                end else begin
                    n_state = S_LINK1;
                end
            end
            S_WISSUE: n_state = (r_mode == MODE_SEARCH) ? S_SRCH : S_WALK;
            S_WALK: begin
                if (r_steps == '0) begin
                    n_state = (r_mode == MODE_INS_POS) ? S_LINK1 : S_DISSUE;
                end
            end
            S_SRCH: begin
                if (val_rdata == r_value || r_idx + 1'b1 == r_count) begin
                    n_state = S_DONE;
                end
            end
            S_LINK1: n_state = (r_count == '0) ? S_DONE : S_LINK2;
            S_LINK2: n_state = S_DONE;
            S_DTAIL: n_state = S_DTAILC;
            S_DTAILC: n_state = S_DISSUE;
            S_DISSUE: n_state = S_DUNLINK;
            S_DUNLINK: n_state = S_DONE;
            S_DONE: n_state = i_ready ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_mode     = r_mode;
        n_value    = r_value;
        n_front    = r_front;
        n_head     = r_head;
        n_count    = r_count;
        n_cur      = r_cur;
        n_at       = r_at;
        n_nx       = r_nx;
        n_node     = r_node;
        n_steps    = r_steps;
        n_idx      = r_idx;
        n_status   = r_status;
        n_removed  = r_removed;
        n_found    = r_found;
        node_raddr = r_cur;
        val_we     = 1'b0;
        nxt_we     = 1'b0;
        prv_we     = 1'b0;
        nxt_waddr  = r_node;
        nxt_wdata  = r_nx;
        prv_waddr  = r_node;
        prv_wdata  = r_at;
        free_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_mode    = i_mode;
                    n_value   = i_value;
                    n_removed = '0;
                    n_found   = '0;
                    n_idx     = '0;
                    n_cur     = r_head;
                    n_steps   = CW'(pos_ext - 32'd1);
                    n_front   = (i_mode == MODE_INS_FRONT) ||
                                (i_mode == MODE_INS_POS && pos_ext == 32'd1);
                    n_status  = ST_OK;
                    case (i_mode)
                        MODE_INS_FRONT, MODE_INS_BACK: begin
                            if (full) n_status = ST_FULL;
                        end
                        MODE_INS_POS: begin
                            if (pos_ext == 32'd0) begin
                                n_status = ST_INVALID;
                            end else if (pos_ext > cnt_ext + 32'd1) begin
                                n_status = ST_OOB;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end
                        end
                        MODE_SEARCH, MODE_DEL_FRONT, MODE_DEL_BACK: begin
                            if (r_count == '0) n_status = ST_EMPTY;
                        end
                        MODE_DEL_POS: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (pos_ext == 32'd0) begin
                                n_status = ST_INVALID;
                            end else if (pos_ext > cnt_ext) begin
                                n_status = ST_OOB;
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_ALLOC: begin
                free_ctl.rd_req = 1'b1;
                node_raddr      = r_head;   // tail = prev of head
            end
            S_GETN: begin
                free_ctl.pop = 1'b1;
                n_node       = free_node;
                n_at         = prv_rdata;
                n_nx         = r_head;
                n_cur        = r_head;
            end
            S_WALK: begin
                if (r_steps != '0) begin
                    n_at       = r_cur;
                    n_cur      = nxt_rdata;
                    n_steps    = r_steps - 1'b1;
                    node_raddr = nxt_rdata;
                end else begin
                    n_nx = r_cur;
                end
            end
            S_SRCH: begin
                if (val_rdata == r_value) begin
                    n_found = r_idx + 1'b1;
                end else if (r_idx + 1'b1 == r_count) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_idx      = r_idx + 1'b1;
                    n_cur      = nxt_rdata;
                    node_raddr = nxt_rdata;
                end
            end
            S_LINK1: begin
                val_we = 1'b1;
                nxt_we = 1'b1;
                prv_we = 1'b1;
                if (r_count == '0) begin
                    // first node links to itself
                    nxt_wdata = r_node;
                    prv_wdata = r_node;
                    n_head    = r_node;
                    n_count   = r_count + 1'b1;
                end
            end
            S_LINK2: begin
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                nxt_waddr = r_at;
                nxt_wdata = r_node;
                prv_waddr = r_nx;
                prv_wdata = r_node;
                n_count   = r_count + 1'b1;
                if (r_front) n_head = r_node;
            end
            S_DTAIL: begin
                node_raddr = r_head;
            end
            S_DTAILC: begin
                n_cur = prv_rdata;
            end
            S_DUNLINK: begin
                n_removed     = val_rdata;
                n_count       = r_count - 1'b1;
                free_ctl.push = 1'b1;
                if (r_count != CW'(1)) begin
                    nxt_we    = 1'b1;
                    prv_we    = 1'b1;
                    nxt_waddr = prv_rdata;
                    nxt_wdata = nxt_rdata;
                    prv_waddr = nxt_rdata;
                    prv_wdata = prv_rdata;
                    if (r_cur == r_head) n_head = nxt_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_mode    <= n_mode;
        r_value   <= n_value;
        r_front   <= n_front;
        r_cur     <= n_cur;
        r_at      <= n_at;
        r_nx      <= n_nx;
        r_node    <= n_node;
        r_steps   <= n_steps;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_found   <= n_found;
    end

    assign o_status         = r_status;
    assign o_removed_value  = r_removed;
    assign o_found_position = CNT_O_W'(r_found);
    assign o_node_count     = CNT_O_W'(r_count);

    `CDLL_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `CDLL_ASSERT_IMP(a_busy_no_req, i_clk, i_rst_n, o_valid, !o_ready)
    `CDLL_ASSERT_NXT(a_unlink_dec, i_clk, i_rst_n, r_state == S_DUNLINK, r_count == $past(r_count) - 1'b1)
    `CDLL_ASSERT_NXT(a_first_head, i_clk, i_rst_n, r_state == S_LINK1 && r_count == '0, r_head == $past(r_node))

endmodule
